FILE: hw/rtl/sspc_pkg.sv
// Shared types, codes and reset values for the servo status packet checker.
`timescale 1ns / 1ps

package sspc_pkg;

    // Default frame buffer size in bytes.
    localparam int FRAME_BYTES_DEF = 64;

    // Field widths.
    localparam int OPCODE_W  = 2;
    localparam int BYTE_W    = 8;
    localparam int DLEN_W    = 6;
    localparam int VERDICT_W = 3;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Input opcodes.
    localparam logic [OPCODE_W-1:0] OP_ARM  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_BYTE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_IDLE = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_TICK = 2'd3;

    // Result kinds.
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict codes.
    localparam logic [VERDICT_W-1:0] VERDICT_OK       = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_TIMEOUT  = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_HEADER   = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_ID       = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_LENGTH   = 3'd4;
    localparam logic [VERDICT_W-1:0] VERDICT_CHECKSUM = 3'd5;
    localparam logic [VERDICT_W-1:0] VERDICT_SHORT    = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_ID      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd4;

    // Configuration reset values.
    localparam logic [BYTE_W-1:0] RST_SERVO_ID      = 8'd1;
    localparam logic [DLEN_W-1:0] RST_DATA_LENGTH   = 6'd0;
    localparam logic [BYTE_W-1:0] RST_HEADER_FIRST  = 8'hFF;
    localparam logic [BYTE_W-1:0] RST_HEADER_SECOND = 8'hFF;
    localparam logic [TICK_W-1:0] RST_TIMEOUT_TICKS = 16'd10;

    typedef struct packed {
        logic [BYTE_W-1:0] servo_id;
        logic [DLEN_W-1:0] data_len;
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [TICK_W-1:0] timeout_ticks;
    } t_cfg;

endpackage

FILE: hw/rtl/sspc_if.sv
// Channel interfaces for the input, result and configuration transactions.
`timescale 1ns / 1ps

interface sspc_in_if;
    import sspc_pkg::*;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [BYTE_W-1:0]   rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface sspc_out_if;
    import sspc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 item_kind;
    logic [BYTE_W-1:0]    data_byte;
    logic [DLEN_W-1:0]    data_index;
    logic [BYTE_W-1:0]    status_byte;
    logic [VERDICT_W-1:0] verdict;
    logic                 frame_done;

    modport source (output valid, output item_kind, output data_byte, output data_index,
                    output status_byte, output verdict, output frame_done, input ready);
    modport sink   (input valid, input item_kind, input data_byte, input data_index,
                    input status_byte, input verdict, input frame_done, output ready);
endinterface

interface sspc_cfg_if;
    import sspc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: hw/rtl/sspc_cfg_regs.sv
// Configuration register file of the servo status packet checker.
`timescale 1ns / 1ps

module sspc_cfg_regs
    import sspc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sspc_cfg_if.sink    i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken; an index past the last register is dropped.
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_SERVO_ID:      n_cfg.servo_id      = i_cfg.wdata[BYTE_W-1:0];
                REG_DATA_LENGTH:   n_cfg.data_len      = i_cfg.wdata[DLEN_W-1:0];
                REG_HEADER_FIRST:  n_cfg.header_first  = i_cfg.wdata[BYTE_W-1:0];
                REG_HEADER_SECOND: n_cfg.header_second = i_cfg.wdata[BYTE_W-1:0];
                REG_TIMEOUT_TICKS: n_cfg.timeout_ticks = i_cfg.wdata[TICK_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.servo_id      <= RST_SERVO_ID;
            r_cfg.data_len      <= RST_DATA_LENGTH;
            r_cfg.header_first  <= RST_HEADER_FIRST;
            r_cfg.header_second <= RST_HEADER_SECOND;
            r_cfg.timeout_ticks <= RST_TIMEOUT_TICKS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: hw/rtl/servo_status_packet_checker.sv
// Top level of the servo status packet checker: frame tracking and result register.
`timescale 1ns / 1ps

// The checker follows one servo status reply frame at a time. An arm transaction
// opens a wait and clears all frame state; received-byte transactions are then
// counted and checked as they arrive: frame byte 0 and 1 against the two header
// registers, byte 2 against servo_id, byte 3 against the data length plus 2,
// byte 4 is kept as the status byte, the next data length bytes are
// forwarded as data items, and the byte after them is compared with the inverted
// 8-bit sum of bytes 2 through the last data byte. Bytes past the checksum are
// counted but not checked, and bytes at frame position FRAME_BYTES and beyond are
// dropped. A line-idle transaction closes the wait with one verdict: short frame
// first, then header, ID, length and checksum faults, else ok. Tick transactions
// count from arming, saturating at 65535, and close the wait with a timeout
// verdict once the count reaches timeout_ticks (zero acts as one). While no wait
// is open, everything but arm is ignored. Every input transaction is handled in
// the cycle it is accepted, so the block takes one transaction per clock; the
// result register is the only limit, and input ready drops only while a result
// sits in it and the result channel is not ready. Each result is held in the
// result register before it is shown on the output. Configuration writes take
// effect on the next cycle, also while a wait is open.
module servo_status_packet_checker
    import sspc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sspc_in_if.sink     i_in,
    sspc_cfg_if.sink    i_cfg,
    sspc_out_if.source  o_out
);

    // Byte counter holds up to FRAME_BYTES; compares are done at a width that
    // also holds 6 + the largest data length.
    localparam int CNT_W = $clog2(FRAME_BYTES + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    t_cfg w_cfg;

    sspc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Frame state.
    logic              r_waiting,       n_waiting;
    logic [CNT_W-1:0]  r_byte_count,    n_byte_count;
    logic [BYTE_W-1:0] r_running_sum,   n_running_sum;
    logic              r_header_good,   n_header_good;
    logic              r_id_good,       n_id_good;
    logic              r_length_good,   n_length_good;
    logic              r_checksum_good, n_checksum_good;
    logic [BYTE_W-1:0] r_held_status,   n_held_status;
    logic [TICK_W-1:0] r_tick_count,    n_tick_count;

    // Result register.
    logic                 r_out_valid,  n_out_valid;
    logic                 r_item_kind,  n_item_kind;
    logic [BYTE_W-1:0]    r_data_byte,  n_data_byte;
    logic [DLEN_W-1:0]    r_data_index, n_data_index;
    logic [BYTE_W-1:0]    r_status,     n_status;
    logic [VERDICT_W-1:0] r_verdict,    n_verdict;
    logic                 r_frame_done, n_frame_done;

    logic              w_in_fire;
    logic              w_produce;
    logic [CMP_W-1:0]  w_pos;
    logic [CMP_W-1:0]  w_dlen;
    logic [CMP_W-1:0]  w_check_pos;
    logic [CMP_W-1:0]  w_min_bytes;
    logic [BYTE_W-1:0] w_sum_add;
    logic [BYTE_W-1:0] w_length_want;

    // A new transaction is taken whenever the result register is free or drains now.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_fire  = i_in.valid && i_in.ready;

    assign w_pos         = CMP_W'(r_byte_count);
    assign w_dlen        = CMP_W'(w_cfg.data_len);
    assign w_check_pos   = w_dlen + CMP_W'(5);
    assign w_min_bytes   = w_dlen + CMP_W'(6);
    assign w_sum_add     = r_running_sum + i_in.rx_byte;
    assign w_length_want = BYTE_W'(w_cfg.data_len) + BYTE_W'(2);

    always_comb begin
        n_waiting       = r_waiting;
        n_byte_count    = r_byte_count;
        n_running_sum   = r_running_sum;
        n_header_good   = r_header_good;
        n_id_good       = r_id_good;
        n_length_good   = r_length_good;
        n_checksum_good = r_checksum_good;
        n_held_status   = r_held_status;
        n_tick_count    = r_tick_count;

        w_produce    = 1'b0;
        n_item_kind  = KIND_DATA;
        n_data_byte  = '0;
        n_data_index = '0;
        n_verdict    = VERDICT_OK;
        n_frame_done = 1'b0;

        if (w_in_fire) begin
            unique case (i_in.opcode)
                OP_ARM: begin
                    n_waiting       = 1'b1;
                    n_byte_count    = '0;
                    n_running_sum   = '0;
                    n_header_good   = 1'b1;
                    n_id_good       = 1'b1;
                    n_length_good   = 1'b1;
                    n_checksum_good = 1'b0;
                    n_held_status   = '0;
                    n_tick_count    = '0;
                end
                OP_BYTE: begin
                    if (r_waiting && (r_byte_count < CNT_W'(FRAME_BYTES))) begin
                        n_byte_count = r_byte_count + CNT_W'(1);
                        if (w_pos == CMP_W'(0)) begin
                            n_header_good = r_header_good
                                            && (i_in.rx_byte == w_cfg.header_first);
                        end else if (w_pos == CMP_W'(1)) begin
                            n_header_good = r_header_good
                                            && (i_in.rx_byte == w_cfg.header_second);
                        end else if (w_pos == CMP_W'(2)) begin
                            n_id_good     = (i_in.rx_byte == w_cfg.servo_id);
                            n_running_sum = w_sum_add;
                        end else if (w_pos == CMP_W'(3)) begin
                            n_length_good = (i_in.rx_byte == w_length_want);
                            n_running_sum = w_sum_add;
                        end else if (w_pos == CMP_W'(4)) begin
                            n_held_status = i_in.rx_byte;
                            n_running_sum = w_sum_add;
                        end else if (w_pos < w_check_pos) begin
                            // Data byte: forwarded with its place in the data field.
                            n_running_sum = w_sum_add;
                            w_produce     = 1'b1;
                            n_item_kind   = KIND_DATA;
                            n_data_byte   = i_in.rx_byte;
                            n_data_index  = DLEN_W'(w_pos - CMP_W'(5));
                        end else if (w_pos == w_check_pos) begin
                            n_checksum_good = (i_in.rx_byte == ~r_running_sum);
                        end
                    end
                end
                OP_IDLE: begin
                    if (r_waiting) begin
                        n_waiting    = 1'b0;
                        w_produce    = 1'b1;
                        n_item_kind  = KIND_VERDICT;
                        n_frame_done = 1'b1;
                        if (w_pos < w_min_bytes) begin
                            n_verdict = VERDICT_SHORT;
                        end else if (!r_header_good) begin
                            n_verdict = VERDICT_HEADER;
                        end else if (!r_id_good) begin
                            n_verdict = VERDICT_ID;
                        end else if (!r_length_good) begin
                            n_verdict = VERDICT_LENGTH;
                        end else if (!r_checksum_good) begin
                            n_verdict = VERDICT_CHECKSUM;
                        end else begin
                            n_verdict = VERDICT_OK;
                        end
                    end
                end
                OP_TICK: begin
                    if (r_waiting) begin
                        if (r_tick_count != '1) begin
                            n_tick_count = r_tick_count + TICK_W'(1);
                        end
                        if (n_tick_count >= w_cfg.timeout_ticks) begin
                            n_waiting    = 1'b0;
                            w_produce    = 1'b1;
                            n_item_kind  = KIND_VERDICT;
                            n_verdict    = VERDICT_TIMEOUT;
                            n_frame_done = 1'b1;
                        end
                    end
                end
                default: begin
                    n_waiting = r_waiting;
                end
            endcase
        end

        // The status byte shown is the one held after this transaction.
        n_status = n_held_status;

        if (w_produce) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting       <= 1'b0;
            r_byte_count    <= '0;
            r_running_sum   <= '0;
            r_header_good   <= 1'b1;
            r_id_good       <= 1'b1;
            r_length_good   <= 1'b1;
            r_checksum_good <= 1'b0;
            r_held_status   <= '0;
            r_tick_count    <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_waiting       <= n_waiting;
            r_byte_count    <= n_byte_count;
            r_running_sum   <= n_running_sum;
            r_header_good   <= n_header_good;
            r_id_good       <= n_id_good;
            r_length_good   <= n_length_good;
            r_checksum_good <= n_checksum_good;
            r_held_status   <= n_held_status;
            r_tick_count    <= n_tick_count;
            r_out_valid     <= n_out_valid;
        end
    end

    // Result payload loads only with a new result, so a stalled result holds.
    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            r_item_kind  <= n_item_kind;
            r_data_byte  <= n_data_byte;
            r_data_index <= n_data_index;
            r_status     <= n_status;
            r_verdict    <= n_verdict;
            r_frame_done <= n_frame_done;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.item_kind   = r_item_kind;
    assign o_out.data_byte   = r_data_byte;
    assign o_out.data_index  = r_data_index;
    assign o_out.status_byte = r_status;
    assign o_out.verdict     = r_verdict;
    assign o_out.frame_done  = r_frame_done;

`ifndef SYNTHESIS
    // Arming always leaves a fresh, open wait.
    a_arm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (i_in.opcode == OP_ARM))
        |=> (r_waiting && (r_byte_count == '0) && (r_tick_count == '0)))
        else $error("arm did not open a clean wait");

    // The byte counter never runs past the frame buffer.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= CNT_W'(FRAME_BYTES))
        else $error("byte count beyond frame buffer");

    // Without an open wait, only arming is acted on and nothing is produced.
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !r_waiting) |-> !w_produce)
        else $error("result produced with no open wait");

    // A verdict closes the wait.
    a_verdict_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_produce && (n_item_kind == KIND_VERDICT)) |=> !r_waiting)
        else $error("wait still open after verdict");

    // A new result never lands on one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_produce |-> (!r_out_valid || o_out.ready))
        else $error("result register overwritten");
`endif

endmodule
